@@ sv/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and pipeline payload types for the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int CW   = 16;          // vertex coordinate width
    localparam int EW   = CW + 1;      // edge width
    localparam int PW   = 2 * EW;      // edge product width
    localparam int MW   = PW;          // cross component magnitude width
    localparam int HW   = MW / 2;      // half of a magnitude for squaring
    localparam int SQW  = 2 * MW;      // square of one component
    localparam int SW   = SQW + 2;     // sum of three squares
    localparam int RW   = SW / 2;      // root width, one bit per sqrt cell
    localparam int REMW = RW + 2;      // sqrt remainder width
    localparam int FB   = 14;          // output fraction bits
    localparam int QW   = FB + 1;      // quotient width, one bit per div cell
    localparam int OW   = FB + 2;      // output component width
    localparam int NHW  = MW + FB - QW; // dividend bits loaded before the steps

    typedef struct packed {
        logic                    valid;
        logic [SW-1:0]           rad;
        logic [RW-1:0]           root;
        logic [REMW-1:0]         rem;
        logic [2:0][MW-1:0]      mag;
        logic [2:0]              neg;
    } sq_t;

    typedef struct packed {
        logic                    valid;
        logic [RW-1:0]           len;
        logic [2:0][RW-1:0]      rem;
        logic [2:0][QW-1:0]      numlo;
        logic [2:0][QW-1:0]      quo;
        logic [2:0]              neg;
        logic                    degen;
    } dv_t;

endpackage

@@ sv/tfn_front.sv @@
// ----------------------------------------------------------------------------
// tfn_front
// Edges, cross product, component magnitudes and the squared length.
// ----------------------------------------------------------------------------
module tfn_front
    import tfn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [9*CW-1:0]      in_data,
    output sq_t                  out
);

    logic [5:0]                  v_reg;
    logic signed [EW-1:0]        e1_reg [3];
    logic signed [EW-1:0]        e2_reg [3];
    logic signed [PW-1:0]        p_reg [3];
    logic signed [PW-1:0]        q_reg [3];
    logic [2:0][MW-1:0]          mag2_reg, mag3_reg, mag4_reg, mag5_reg;
    logic [2:0]                  neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [PW-1:0]               hh_reg [3];
    logic [PW-1:0]               hl_reg [3];
    logic [PW-1:0]               ll_reg [3];
    logic [SQW-1:0]              sq_reg [3];
    logic [SW-1:0]               sum_reg;

    logic signed [CW-1:0]        vtx [9];
    logic signed [PW:0]          diff [3];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            vtx[i] = in_data[i*CW +: CW];
        end
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {p_reg[i][PW-1], p_reg[i]} - {q_reg[i][PW-1], q_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= {vtx[3+i][CW-1], vtx[3+i]} - {vtx[i][CW-1], vtx[i]};
                e2_reg[i] <= {vtx[6+i][CW-1], vtx[6+i]} - {vtx[i][CW-1], vtx[i]};
            end
            p_reg[0] <= e2_reg[1] * e1_reg[2];
            q_reg[0] <= e2_reg[2] * e1_reg[1];
            p_reg[1] <= e2_reg[2] * e1_reg[0];
            q_reg[1] <= e2_reg[0] * e1_reg[2];
            p_reg[2] <= e2_reg[0] * e1_reg[1];
            q_reg[2] <= e2_reg[1] * e1_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                neg2_reg[i] <= diff[i][PW];
                mag2_reg[i] <= diff[i][PW] ? MW'(-diff[i]) : MW'(diff[i]);
                hh_reg[i]   <= mag2_reg[i][MW-1:HW] * mag2_reg[i][MW-1:HW];
                hl_reg[i]   <= mag2_reg[i][MW-1:HW] * mag2_reg[i][HW-1:0];
                ll_reg[i]   <= mag2_reg[i][HW-1:0] * mag2_reg[i][HW-1:0];
                sq_reg[i]   <= {hh_reg[i], {MW{1'b0}}}
                             + {{(HW-1){1'b0}}, hl_reg[i], {(HW+1){1'b0}}}
                             + {{MW{1'b0}}, ll_reg[i]};
            end
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
            sum_reg  <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        end
    end

    assign out.valid = v_reg[5];
    assign out.rad   = sum_reg;
    assign out.root  = '0;
    assign out.rem   = '0;
    assign out.mag   = mag5_reg;
    assign out.neg   = neg5_reg;

endmodule

@@ sv/tfn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One root bit of the integer square root: takes two radicand bits a cycle while en is high.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell
    import tfn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  sq_t  in,
    output sq_t  out
);

    sq_t             out_reg;
    logic [REMW+1:0] rem_sh;
    logic [REMW+1:0] trial;
    logic            take;

    always_comb
    begin
        rem_sh = {in.rem, in.rad[SW-1:SW-2]};
        trial  = {{(REMW-RW){1'b0}}, in.root, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (en)
        begin
            out_reg.valid <= in.valid;
            out_reg.rad   <= {in.rad[SW-3:0], 2'b00};
            out_reg.root  <= {in.root[RW-2:0], take};
            out_reg.rem   <= take ? REMW'(rem_sh - trial) : REMW'(rem_sh);
            out_reg.mag   <= in.mag;
            out_reg.neg   <= in.neg;
        end
    end

    assign out = out_reg;

endmodule

@@ sv/tfn_div_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_div_cell
// One quotient bit of the three component divisions by the length.
// ----------------------------------------------------------------------------
module tfn_div_cell
    import tfn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  dv_t  in,
    output dv_t  out
);

    dv_t           out_reg;
    logic [RW:0]   r_sh [3];
    logic [2:0]    take;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_sh[i] = {in.rem[i], in.numlo[i][QW-1]};
            take[i] = r_sh[i] >= {1'b0, in.len};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (en)
        begin
            out_reg.valid <= in.valid;
            for (int i = 0; i < 3; i++)
            begin
                out_reg.rem[i]   <= take[i] ? RW'(r_sh[i] - {1'b0, in.len}) : RW'(r_sh[i]);
                out_reg.numlo[i] <= {in.numlo[i][QW-2:0], 1'b0};
                out_reg.quo[i]   <= {in.quo[i][QW-2:0], take[i]};
            end
            out_reg.len   <= in.len;
            out_reg.neg   <= in.neg;
            out_reg.degen <= in.degen;
        end
    end

    assign out = out_reg;

endmodule

@@ sv/triangle_face_normal_top.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle in signed Q1.14 from Q8.8 vertices.
// ----------------------------------------------------------------------------
// The unit takes one triangle per cycle while its output buffer has a free
// entry. The path is 57 register stages, the first loaded at the accepting
// edge: six for edges, cross product and squared length, one per root bit
// in a row of 35 square root cells, one per quotient bit in a row of
// 15 divider cells, then the output register. A two-entry output buffer lets
// one more result leave the pipeline while a result waits; after that the
// whole pipeline holds until the output drains. A degenerate triangle returns
// the zero vector with the degenerate flag set.
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, 16 bits each
    input  logic [9*CW-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // normal_x, normal_y, normal_z, 16 bits each
    output logic [3*OW-1:0]  m_tdata,
    // degenerate
    output logic [0:0]       m_tuser
);

    logic               en;
    sq_t                sq_chain [RW+1];
    dv_t                dv_chain [QW+1];
    logic [3*OW-1:0]    res_data;
    logic               res_valid;
    logic               out_v_reg, skid_v_reg;
    logic [3*OW-1:0]    out_d_reg, skid_d_reg;
    logic               out_u_reg, skid_u_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    tfn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .out      (sq_chain[0])
    );

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        tfn_sqrt_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in    (sq_chain[g]),
            .out   (sq_chain[g+1])
        );
    end

    // load the dividers: dividend is magnitude shifted up by the fraction bits
    always_comb
    begin
        dv_chain[0].valid = sq_chain[RW].valid;
        dv_chain[0].len   = sq_chain[RW].root;
        dv_chain[0].neg   = sq_chain[RW].neg;
        dv_chain[0].degen = sq_chain[RW].root == '0;
        dv_chain[0].quo   = '0;
        for (int i = 0; i < 3; i++)
        begin
            dv_chain[0].rem[i]   = {{(RW-NHW){1'b0}}, sq_chain[RW].mag[i][MW-1:QW-FB]};
            dv_chain[0].numlo[i] = {sq_chain[RW].mag[i][QW-FB-1:0], {FB{1'b0}}};
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        tfn_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in    (dv_chain[g]),
            .out   (dv_chain[g+1])
        );
    end

    always_comb
    begin
        res_valid = dv_chain[QW].valid && en;
        for (int i = 0; i < 3; i++)
        begin
            if (dv_chain[QW].degen)
            begin
                res_data[i*OW +: OW] = '0;
            end
            else if (dv_chain[QW].neg[i])
            begin
                res_data[i*OW +: OW] = OW'(-{1'b0, dv_chain[QW].quo[i]});
            end
            else
            begin
                res_data[i*OW +: OW] = OW'({1'b0, dv_chain[QW].quo[i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_v_reg && !m_tready)
            begin
                skid_v_reg <= 1'b1;
            end
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_d_reg <= skid_d_reg;
                out_u_reg <= skid_u_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_v_reg || m_tready)
            begin
                out_d_reg <= res_data;
                out_u_reg <= dv_chain[QW].degen;
            end
            else
            begin
                skid_d_reg <= res_data;
                skid_u_reg <= dv_chain[QW].degen;
            end
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_d_reg;
    assign m_tuser[0] = out_u_reg;

endmodule
